// ===== rtl/core/smbc_pkg.sv =====
// smbc_pkg: shared sizes, codes and types for the shadow memory bounds checker
// used by smbc_shadow_ram and shadow_memory_bounds_checker_top
// no dependencies
package smbc_pkg;

  // storage and redzone geometry
  localparam int SHADOW_ENTRIES = 1024;
  localparam int REDZONE_BYTES  = 32;
  localparam int IDX_W          = $clog2(SHADOW_ENTRIES);
  localparam int RZ_GRANULES    = REDZONE_BYTES / 8;

  // field widths
  localparam int BASE_W = 29;
  localparam int ADDR_W = 32;
  localparam int SIZE_W = 16;
  localparam int OFF_W  = 16;
  localparam int DATA_W = 8;

  // granule arithmetic: 33-bit sums over 8 plus the redzone span
  localparam int GRAN_W = ADDR_W - 1;
  localparam int TAIL_W = ADDR_W - 2;
  // granule counter holds a user granule count or a redzone length
  localparam int UCNT_W = SIZE_W - 3;
  localparam int CNT_W  = UCNT_W;

  localparam logic [DATA_W-1:0] SHADOW_POISON = 8'hff;
  localparam logic [DATA_W-1:0] SHADOW_CLEAR  = 8'h00;

  typedef enum logic [1:0] {
    STATUS_OK           = 2'd0,
    STATUS_OVERFLOW     = 2'd1,
    STATUS_OUT_OF_RANGE = 2'd2
  } status_t;

  typedef enum logic {
    MODE_ALLOC = 1'b0,
    MODE_CHECK = 1'b1
  } mode_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ACHK,
    ST_LEAD,
    ST_USER,
    ST_TAIL,
    ST_PART
  } state_t;

  // shadow store write and read requests
  typedef struct packed {
    logic              en;
    logic [IDX_W-1:0]  addr;
    logic [DATA_W-1:0] data;
  } shadow_wr_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
  } shadow_rd_t;

  // granule lies at or above the base and less than SHADOW_ENTRIES past it
  function automatic logic in_window(logic [GRAN_W-1:0] g, logic [BASE_W-1:0] base);
    logic [GRAN_W:0] diff;
    diff = {1'b0, g} - {{(GRAN_W + 1 - BASE_W){1'b0}}, base};
    return !diff[GRAN_W] && (diff[GRAN_W-1:0] < GRAN_W'(SHADOW_ENTRIES));
  endfunction

endpackage

// ===== rtl/core/smbc_shadow_ram.sv =====
// smbc_shadow_ram: shadow byte store, one write and one registered read a cycle
// depends on smbc_pkg
module smbc_shadow_ram (
  input  logic                         clk,
  input  smbc_pkg::shadow_wr_t         wr,
  input  smbc_pkg::shadow_rd_t         rd,
  output logic [smbc_pkg::DATA_W-1:0]  rd_data
);
  import smbc_pkg::*;

  logic [DATA_W-1:0] mem [SHADOW_ENTRIES];

  // write port
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_data <= mem[rd.addr];
    end
  end

endmodule

// ===== rtl/core/shadow_memory_bounds_checker_top.sv =====
// shadow_memory_bounds_checker_top: allocate and check against a shadow byte store
// depends on smbc_pkg and smbc_shadow_ram
//
// Usage: the configuration channel (cfg_valid/cfg_ready) loads window_base_granule, the
// granule number mapped to shadow index zero; it is always ready. The input channel takes
// one transaction of mode, address, alloc_size and access_offset; the output channel
// returns status, user_address and shadow_value for each one, in order.
// A check transaction reads one shadow byte as it is accepted: its result passes through
// the result stage, beside the registered read, and then the output register. Checks are
// accepted one per cycle while the block is idle and the output side does not stall. An
// allocation first runs the window test, then writes the shadow store one granule a
// cycle: 2*RZ_GRANULES + alloc_size/8 writes, plus one when alloc_size mod 8 is nonzero,
// and in_ready stays low until the writes finish. Its result enters the result stage as
// the writes begin. An allocation out of window returns to idle after the window test
// and writes nothing. After reset a clearing pass zeroes all SHADOW_ENTRIES (1024)
// entries, one entry a cycle, with in_ready low; configuration writes are still taken.
// When the receiver stalls, the output register and one stage behind it hold results
// and in_ready drops once both are full.
module shadow_memory_bounds_checker_top (
  input  logic                          clk,
  input  logic                          rst,
  // configuration
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [smbc_pkg::BASE_W-1:0]   window_base_granule,
  // input transactions
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          mode,
  input  logic [smbc_pkg::ADDR_W-1:0]   address,
  input  logic [smbc_pkg::SIZE_W-1:0]   alloc_size,
  input  logic [smbc_pkg::OFF_W-1:0]    access_offset,
  // result transactions
  output logic                          out_valid,
  input  logic                          out_ready,
  output smbc_pkg::status_t             status,
  output logic [smbc_pkg::ADDR_W-1:0]   user_address,
  output logic [smbc_pkg::DATA_W-1:0]   shadow_value
);
  import smbc_pkg::*;

  state_t state, state_next;

  logic [BASE_W-1:0] base;
  logic [IDX_W-1:0]  clr_idx;

  // pending allocation
  logic [ADDR_W-1:0] a_addr;
  logic [SIZE_W-1:0] a_size;
  logic [TAIL_W-1:0] a_tail_g;

  // fill sequencer
  logic [IDX_W-1:0]  wr_idx;
  logic [CNT_W-1:0]  cnt;
  logic [UCNT_W-1:0] ucnt;
  logic [2:0]        rem;
  logic [IDX_W-1:0]  tail_idx;
  logic [IDX_W-1:0]  part_idx;

  // result stage in front of the output register
  logic              s1_valid;
  logic              s1_check;
  logic              s1_ok;
  logic [ADDR_W-1:0] s1_user;
  logic [2:0]        s1_low3;

  logic              s1_move;
  logic              s1_free;
  logic              accept;
  logic              chk_go;
  logic              achk_go;
  logic              cnt_last;

  shadow_wr_t        ram_wr;
  shadow_rd_t        ram_rd;
  logic [DATA_W-1:0] rd_data;

  // check address arithmetic
  logic [ADDR_W:0]   chk_sum;
  logic [GRAN_W-1:0] chk_g;
  logic              chk_ok;

  // allocation arithmetic
  logic [ADDR_W:0]   alloc_sum;
  logic [GRAN_W-1:0] lo_g;
  logic [GRAN_W-1:0] hi_g;
  logic              alloc_ok;
  logic [IDX_W-1:0]  lo_idx;

  // result computation
  status_t           res_status;
  logic [DATA_W-1:0] res_sval;

  assign cfg_ready = 1'b1;

  assign s1_move  = s1_valid && (!out_valid || out_ready);
  assign s1_free  = !s1_valid || s1_move;
  assign accept   = in_valid && in_ready;
  assign chk_go   = accept && (mode == MODE_CHECK);
  assign cnt_last = (cnt == CNT_W'(1));

  // check: granule of address plus offset, and whether it lies in the window
  assign chk_sum = {1'b0, address} + (ADDR_W + 1)'(access_offset);
  assign chk_g   = GRAN_W'(chk_sum[ADDR_W:3]);
  assign chk_ok  = in_window(chk_g, base);

  // allocation: trailing redzone start from u + n, lowest and highest granule touched
  assign alloc_sum = {1'b0, address} + (ADDR_W + 1)'(REDZONE_BYTES)
                     + (ADDR_W + 1)'(alloc_size);
  assign lo_g      = GRAN_W'(a_addr[ADDR_W-1:3]);
  assign hi_g      = GRAN_W'(a_tail_g) + GRAN_W'(RZ_GRANULES - 1);
  assign alloc_ok  = in_window(lo_g, base) && in_window(hi_g, base);
  assign lo_idx    = a_addr[IDX_W+2:3] - base[IDX_W-1:0];

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      base <= '0;
    end else if (cfg_valid && cfg_ready) begin
      base <= window_base_granule;
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_idx == IDX_W'(SHADOW_ENTRIES - 1)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept && (mode == MODE_ALLOC)) state_next = ST_ACHK;
      end
      ST_ACHK: begin
        if (s1_free) state_next = alloc_ok ? ST_LEAD : ST_IDLE;
      end
      ST_LEAD: begin
        if (cnt_last) state_next = (ucnt != '0) ? ST_USER : ST_TAIL;
      end
      ST_USER: begin
        if (cnt_last) state_next = ST_TAIL;
      end
      ST_TAIL: begin
        if (cnt_last) state_next = (rem != '0) ? ST_PART : ST_IDLE;
      end
      ST_PART: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // state outputs: handshake and shadow writes
  always_comb begin
    in_ready     = 1'b0;
    achk_go      = 1'b0;
    ram_wr.en    = 1'b0;
    ram_wr.addr  = wr_idx;
    ram_wr.data  = SHADOW_CLEAR;
    case (state)
      ST_CLEAR: begin
        ram_wr.en   = 1'b1;
        ram_wr.addr = clr_idx;
      end
      ST_IDLE: begin
        in_ready = s1_free;
      end
      ST_ACHK: begin
        achk_go = s1_free;
      end
      ST_LEAD, ST_TAIL: begin
        ram_wr.en   = 1'b1;
        ram_wr.data = SHADOW_POISON;
      end
      ST_USER: begin
        ram_wr.en = 1'b1;
      end
      ST_PART: begin
        ram_wr.en   = 1'b1;
        ram_wr.data = DATA_W'(rem);
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // clearing pass counter
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx <= '0;
    end else if (state == ST_CLEAR) begin
      clr_idx <= clr_idx + IDX_W'(1);
    end
  end

  // capture an allocation
  always_ff @(posedge clk) begin
    if (accept && (mode == MODE_ALLOC)) begin
      a_addr   <= address;
      a_size   <= alloc_size;
      a_tail_g <= alloc_sum[ADDR_W:3];
    end
  end

  // fill sequencer: leading redzone, user granules, trailing redzone, partial granule
  always_ff @(posedge clk) begin
    case (state)
      ST_ACHK: begin
        wr_idx   <= lo_idx;
        cnt      <= CNT_W'(RZ_GRANULES);
        ucnt     <= a_size[SIZE_W-1:3];
        rem      <= a_size[2:0];
        tail_idx <= a_tail_g[IDX_W-1:0] - base[IDX_W-1:0];
        part_idx <= lo_idx + IDX_W'(RZ_GRANULES) + IDX_W'(a_size[SIZE_W-1:3]);
      end
      ST_LEAD: begin
        if (cnt_last && (ucnt == '0)) begin
          wr_idx <= tail_idx;
          cnt    <= CNT_W'(RZ_GRANULES);
        end else begin
          wr_idx <= wr_idx + IDX_W'(1);
          cnt    <= cnt_last ? CNT_W'(ucnt) : cnt - CNT_W'(1);
        end
      end
      ST_USER: begin
        if (cnt_last) begin
          wr_idx <= tail_idx;
          cnt    <= CNT_W'(RZ_GRANULES);
        end else begin
          wr_idx <= wr_idx + IDX_W'(1);
          cnt    <= cnt - CNT_W'(1);
        end
      end
      ST_TAIL: begin
        wr_idx <= cnt_last ? part_idx : wr_idx + IDX_W'(1);
        cnt    <= cnt - CNT_W'(1);
      end
      default: begin
        wr_idx <= wr_idx;
      end
    endcase
  end

  // shadow read issued as a check is accepted
  assign ram_rd.en   = chk_go;
  assign ram_rd.addr = chk_g[IDX_W-1:0] - base[IDX_W-1:0];

  smbc_shadow_ram u_shadow_ram (
    .clk     (clk),
    .wr      (ram_wr),
    .rd      (ram_rd),
    .rd_data (rd_data)
  );

  // result stage control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (chk_go || achk_go) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  // result stage payload
  always_ff @(posedge clk) begin
    if (chk_go) begin
      s1_check <= 1'b1;
      s1_ok    <= chk_ok;
      s1_user  <= '0;
      s1_low3  <= chk_sum[2:0];
    end else if (achk_go) begin
      s1_check <= 1'b0;
      s1_ok    <= alloc_ok;
      s1_user  <= a_addr + ADDR_W'(REDZONE_BYTES);
      s1_low3  <= '0;
    end
  end

  // status from the window test and the shadow byte
  always_comb begin
    res_status = STATUS_OK;
    res_sval   = '0;
    if (!s1_ok) begin
      res_status = STATUS_OUT_OF_RANGE;
    end else if (s1_check) begin
      res_sval = rd_data;
      if ((rd_data == SHADOW_POISON) ||
          ((rd_data != SHADOW_CLEAR) && (rd_data <= DATA_W'(s1_low3)))) begin
        res_status = STATUS_OVERFLOW;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_move) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      status       <= res_status;
      user_address <= s1_user;
      shadow_value <= res_sval;
    end
  end

endmodule

// ===== tb/tb_top.sv =====
// tb_top: self-checking testbench for shadow_memory_bounds_checker_top
// holds a shadow-store tracker class plus the stimulus, back-pressure and watchdog processes
// depends on smbc_pkg and the block's rtl
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import smbc_pkg::*;

  localparam int LIMIT_CYCLES = 5000000;
  localparam int HOLD_CYCLES  = 400;
  // longest shadow write run an allocation can leave behind its result, plus a margin
  localparam int DRAIN_CYCLES = 2 * RZ_GRANULES + (1 << SIZE_W) / 8 + 16;
  localparam int WINDOW_BYTES = SHADOW_ENTRIES * 8;
  localparam int WIDE_W       = ADDR_W + 2;
  localparam logic [BASE_W-1:0] TOP_BASE = '1;

  typedef logic [WIDE_W-1:0] wide_t;

  typedef struct {
    status_t           status;
    logic [ADDR_W-1:0] user_address;
    logic [DATA_W-1:0] shadow_value;
  } shadow_result_t;

  // mirror of the shadow store plus the queue of results still owed by the block
  class shadow_tracker;
    logic [DATA_W-1:0] shadow_bytes [SHADOW_ENTRIES];
    logic [BASE_W-1:0] window_base;
    shadow_result_t    pending_results [$];
    int errors, allocs, checks, overflows, out_of_window;

    function new();
      foreach (shadow_bytes[i]) shadow_bytes[i] = SHADOW_CLEAR;
      window_base = '0;
      errors = 0;
      allocs = 0;
      checks = 0;
      overflows = 0;
      out_of_window = 0;
    endfunction

    // granule number to store slot, false when outside the window
    function bit granule_slot(input wide_t g, output int unsigned slot);
      wide_t d;
      slot = 0;
      if (g < wide_t'(window_base)) return 1'b0;
      d = g - wide_t'(window_base);
      if (d >= wide_t'(SHADOW_ENTRIES)) return 1'b0;
      slot = int'(d);
      return 1'b1;
    endfunction

    function void fill_span(input wide_t g, input int unsigned count, input logic [DATA_W-1:0] v);
      int unsigned slot;
      for (int unsigned k = 0; k < count; k++) begin
        if (granule_slot(g + k, slot)) shadow_bytes[slot] = v;
      end
    endfunction

    // accepted input transaction: update the store and queue the result it owes
    function void note_request(input mode_t m, input logic [ADDR_W-1:0] a,
                               input logic [SIZE_W-1:0] n, input logic [OFF_W-1:0] o);
      shadow_result_t r;
      wide_t user, g_lo, g_tail, g_hi, g_user, g_part, byte_addr;
      int unsigned slot;
      r.status = STATUS_OK;
      r.user_address = '0;
      r.shadow_value = '0;
      if (m == MODE_ALLOC) begin
        allocs++;
        user   = wide_t'(a) + REDZONE_BYTES;
        g_lo   = wide_t'(a) >> 3;
        g_tail = (user + n) >> 3;
        g_hi   = g_tail + RZ_GRANULES - 1;
        g_user = user >> 3;
        g_part = g_user + (n >> 3);
        if (g_part > g_hi) g_hi = g_part;
        r.user_address = user[ADDR_W-1:0];
        if (!granule_slot(g_lo, slot) || !granule_slot(g_hi, slot)) begin
          r.status = STATUS_OUT_OF_RANGE;
        end else begin
          // leading redzone, user area, trailing redzone, then the partial granule
          fill_span(g_lo, RZ_GRANULES, SHADOW_POISON);
          fill_span(g_user, n >> 3, SHADOW_CLEAR);
          fill_span(g_tail, RZ_GRANULES, SHADOW_POISON);
          if (n[2:0] != 3'd0) fill_span(g_part, 1, DATA_W'(n[2:0]));
        end
      end else begin
        checks++;
        byte_addr = wide_t'(a) + o;
        if (!granule_slot(byte_addr >> 3, slot)) begin
          r.status = STATUS_OUT_OF_RANGE;
        end else begin
          r.shadow_value = shadow_bytes[slot];
          if (r.shadow_value == SHADOW_POISON ||
              (r.shadow_value != SHADOW_CLEAR && r.shadow_value <= byte_addr[2:0])) begin
            r.status = STATUS_OVERFLOW;
          end
        end
      end
      if (r.status == STATUS_OVERFLOW) overflows++;
      if (r.status == STATUS_OUT_OF_RANGE) out_of_window++;
      pending_results.push_back(r);
    endfunction

    // accepted result transaction against the oldest owed result
    function void check_result(input status_t got_status, input logic [ADDR_W-1:0] got_user,
                               input logic [DATA_W-1:0] got_shadow);
      shadow_result_t e;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: result with nothing owed: status %0d user_address %h shadow_value %h",
                 $time, got_status, got_user, got_shadow);
        return;
      end
      e = pending_results.pop_front();
      if (got_status !== e.status) begin
        errors++;
        $display("%0t: status mismatch: expected %0d, got %0d", $time, e.status, got_status);
      end
      if (got_user !== e.user_address) begin
        errors++;
        $display("%0t: user_address mismatch: expected %h, got %h",
                 $time, e.user_address, got_user);
      end
      if (got_shadow !== e.shadow_value) begin
        errors++;
        $display("%0t: shadow_value mismatch: expected %h, got %h",
                 $time, e.shadow_value, got_shadow);
      end
    endfunction
  endclass

  logic              clk;
  logic              rst;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [BASE_W-1:0] window_base_granule;
  logic              in_valid;
  logic              in_ready;
  logic              mode;
  logic [ADDR_W-1:0] address;
  logic [SIZE_W-1:0] alloc_size;
  logic [OFF_W-1:0]  access_offset;
  logic              out_valid;
  logic              out_ready;
  status_t           status;
  logic [ADDR_W-1:0] user_address;
  logic [DATA_W-1:0] shadow_value;

  shadow_tracker tracker = new();
  int  send_idle_pct = 16;
  int  take_idle_pct = 16;
  bit  hold_request = 1'b0;
  int  settings_used = 0;
  int  cycle_count;

  shadow_memory_bounds_checker_top dut (
    .clk                 (clk),
    .rst                 (rst),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .window_base_granule (window_base_granule),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .mode                (mode),
    .address             (address),
    .alloc_size          (alloc_size),
    .access_offset       (access_offset),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .status              (status),
    .user_address        (user_address),
    .shadow_value        (shadow_value)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("%0t: run still busy after %0d cycles", $time, LIMIT_CYCLES);
    $display("shadow_memory_bounds_checker_top verification failed");
    $finish;
  end

  // sample every handshake at the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) tracker.window_base = window_base_granule;
      if (in_valid && in_ready) begin
        tracker.note_request(mode_t'(mode), address, alloc_size, access_offset);
      end
      if (out_valid && out_ready) tracker.check_result(status, user_address, shadow_value);
    end
  end

  // result side: random stalls, plus a long hold-off when asked
  initial begin
    int hold_left;
    hold_left = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(99) >= take_idle_pct);
      end
    end
  end

  // offer one input transaction and wait for it to be taken
  task automatic offer(input mode_t m, input logic [ADDR_W-1:0] a,
                       input logic [SIZE_W-1:0] n, input logic [OFF_W-1:0] o);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    mode          <= m;
    address       <= a;
    alloc_size    <= n;
    access_offset <= o;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic write_window(input logic [BASE_W-1:0] b);
    @(negedge clk);
    cfg_valid <= 1'b1;
    window_base_granule <= b;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  // stop offering, collect every owed result, then let trailing shadow writes finish
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (tracker.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // one window setting: mostly allocations followed by probing checks, some noise
  task automatic run_phase(input logic [BASE_W-1:0] b, input int items, input bit with_hold);
    wide_t window_lo, place;
    logic [ADDR_W-1:0] raw, user;
    logic [SIZE_W-1:0] n;
    int sent, k, pick;
    bit held;
    write_window(b);
    window_lo = wide_t'(b) << 3;
    sent = 0;
    held = 1'b0;
    while (sent < items) begin
      if (with_hold && !held && sent >= items / 2) begin
        hold_request = 1'b1;
        held = 1'b1;
      end
      pick = $urandom_range(99);
      if (pick < 8) begin
        // unshaped transaction anywhere in the address space
        offer(mode_t'($urandom_range(1)), $urandom, SIZE_W'($urandom_range(16'hffff)),
              OFF_W'($urandom_range(16'hffff)));
        sent++;
      end else if (pick < 15) begin
        // stray check somewhere in the window
        place = window_lo + $urandom_range(WINDOW_BYTES - 1);
        offer(MODE_CHECK, place[ADDR_W-1:0], SIZE_W'($urandom_range(16'hffff)),
              OFF_W'($urandom_range(15)));
        sent++;
      end else begin
        // mostly small regions, a few large ones, a few too big for any window
        pick = $urandom_range(99);
        if (pick < 3) n = SIZE_W'($urandom_range(4000, 1000));
        else if (pick < 6) n = '1;
        else n = SIZE_W'($urandom_range(160));
        place = window_lo;
        if (int'(n) + 72 < WINDOW_BYTES) begin
          place += $urandom_range(WINDOW_BYTES - 72 - int'(n)) & ~32'd7;
        end
        if ($urandom_range(9) == 0) place += $urandom_range(7, 1);
        if (place > wide_t'(32'hffff_ffff)) place = wide_t'(32'hffff_fff8);
        raw  = place[ADDR_W-1:0];
        user = raw + REDZONE_BYTES;
        offer(MODE_ALLOC, raw, n, OFF_W'($urandom_range(16'hffff)));
        k = $urandom_range(6, 2);
        for (int j = 0; j < k; j++) begin
          pick = $urandom_range(9);
          if (pick < 2) begin
            offer(MODE_CHECK, raw, SIZE_W'($urandom_range(16'hffff)),
                  OFF_W'($urandom_range(REDZONE_BYTES - 1)));
          end else if (pick < 6) begin
            offer(MODE_CHECK, user, SIZE_W'($urandom_range(16'hffff)),
                  OFF_W'($urandom_range(int'(n) + 40)));
          end else begin
            offer(MODE_CHECK, raw, SIZE_W'($urandom_range(16'hffff)),
                  OFF_W'(REDZONE_BYTES + $urandom_range(int'(n) + 40)));
          end
        end
        sent += 1 + k;
      end
    end
    settle();
  endtask

  // stimulus
  initial begin
    rst = 1'b1;
    cfg_valid = 1'b0;
    window_base_granule = '0;
    in_valid = 1'b0;
    mode = MODE_ALLOC;
    address = '0;
    alloc_size = '0;
    access_offset = '0;
    repeat (2) @(negedge clk);
    rst <= 1'b0;

    // directed: window at zero
    write_window('0);
    offer(MODE_CHECK, 32'd0, 16'd0, 16'd0);
    offer(MODE_ALLOC, 32'd0, 16'd0, 16'd0);          // zero size, redzones only
    offer(MODE_CHECK, 32'd32, 16'd0, 16'd0);
    offer(MODE_ALLOC, 32'd64, 16'd13, 16'd0);        // partial granule of five bytes
    offer(MODE_CHECK, 32'd96, 16'd0, 16'd8);
    offer(MODE_CHECK, 32'd96, 16'd0, 16'd12);
    offer(MODE_CHECK, 32'd96, 16'd0, 16'd13);
    offer(MODE_CHECK, 32'd96, 16'd0, 16'd0);
    offer(MODE_ALLOC, 32'd203, 16'd8, 16'd0);        // unaligned raw block
    offer(MODE_CHECK, 32'd235, 16'd0, 16'd7);
    offer(MODE_ALLOC, 32'd0, 16'hffff, 16'hffff);    // far too big for the window
    offer(MODE_ALLOC, 32'hffff_fff8, 16'd0, 16'd0);  // user address wraps
    offer(MODE_CHECK, 32'hffff_ffff, 16'hffff, 16'hffff);
    offer(MODE_CHECK, 32'd8191, 16'd0, 16'd0);       // last granule of the window
    offer(MODE_CHECK, 32'd8192, 16'd0, 16'd0);       // first granule past it
    offer(MODE_ALLOC, 32'd8128, 16'd0, 16'd0);       // ends on the last granule
    offer(MODE_ALLOC, 32'd8128, 16'd8, 16'd0);       // one granule too far
    offer(MODE_ALLOC, 32'd256, 16'd7000, 16'd0);
    offer(MODE_CHECK, 32'd288, 16'd0, 16'd6999);
    offer(MODE_CHECK, 32'd288, 16'd0, 16'd7000);
    offer(MODE_ALLOC, 32'd8000, 16'd7, 16'd0);       // partial granule only
    offer(MODE_CHECK, 32'd8032, 16'd0, 16'd6);
    settle();

    // directed: window at the top, sums carry past 32 bits
    write_window(TOP_BASE);
    offer(MODE_ALLOC, 32'hffff_fff8, 16'd100, 16'd0);
    offer(MODE_CHECK, 32'hffff_fff8, 16'd0, 16'(REDZONE_BYTES + 99));
    offer(MODE_CHECK, 32'hffff_fff8, 16'd0, 16'(REDZONE_BYTES + 100));
    settle();

    // random phases over several window settings
    run_phase(BASE_W'($urandom_range(29'h1fff_ffff)), 180, 1'b1);
    send_idle_pct = 0;
    take_idle_pct = 0;
    run_phase('0, 180, 1'b0);
    send_idle_pct = 16;
    take_idle_pct = 16;
    run_phase(29'h1fff_fe00, 170, 1'b0);
    run_phase(TOP_BASE, 170, 1'b0);
    run_phase(BASE_W'($urandom_range(4096, 1)), 170, 1'b0);

    $display("covered %0d allocations and %0d checks across %0d window settings",
             tracker.allocs, tracker.checks, settings_used);
    $display("outcomes included %0d overflows and %0d out-of-window transactions",
             tracker.overflows, tracker.out_of_window);
    if (tracker.errors == 0 && tracker.pending_results.size() == 0) begin
      $display("shadow_memory_bounds_checker_top verification clean");
    end else begin
      $display("shadow_memory_bounds_checker_top verification failed");
    end
    $finish;
  end

endmodule
